[hdl/cta_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cta_pkg: shared types and constants of the circle track associator
// Holds the request and result codes, the configuration register indexes,
// the table entry layout and the command and status bundles that join the
// controller to the datapath.
// ============================================================================
package cta_pkg;

   // Field widths of the transaction payloads.
   localparam int COORD_W   = 14;
   localparam int STEP_W    = 15;
   localparam int VOTES_W   = 8;
   localparam int ACTION_W  = 3;
   localparam int SLOT_W    = 4;
   localparam int CFG_IDX_W = 3;
   localparam int CFG_DAT_W = 15;

   // Votes must exceed this count for a candidate to be used.
   localparam logic [VOTES_W-1:0] VOTE_LIMIT = 8'd15;

   // Request type codes.
   localparam logic REQ_FRAME = 1'b0;
   localparam logic REQ_CAND  = 1'b1;

   // Configuration register indexes.
   localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 3'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_MIN_RADIUS  = 3'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_MAX_RADIUS  = 3'd2;
   localparam logic [CFG_IDX_W-1:0] CFG_MIN_X_STEP  = 3'd3;
   localparam logic [CFG_IDX_W-1:0] CFG_MAX_X_STEP  = 3'd4;
   localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y_DIFF  = 3'd5;
   localparam logic [CFG_IDX_W-1:0] CFG_MAX_R_DIFF  = 3'd6;
   localparam logic [CFG_IDX_W-1:0] CFG_NEW_GAP     = 3'd7;

   // Configuration reset values.
   localparam logic [COORD_W-1:0]       RST_FRAME_WIDTH = 14'd2560;
   localparam logic [COORD_W-1:0]       RST_MIN_RADIUS  = 14'd80;
   localparam logic [COORD_W-1:0]       RST_MAX_RADIUS  = 14'd400;
   localparam logic signed [STEP_W-1:0] RST_MIN_X_STEP  = 15'sd0;
   localparam logic signed [STEP_W-1:0] RST_MAX_X_STEP  = 15'sd400;
   localparam logic [COORD_W-1:0]       RST_MAX_Y_DIFF  = 14'd40;
   localparam logic [COORD_W-1:0]       RST_MAX_R_DIFF  = 14'd40;
   localparam logic signed [STEP_W-1:0] RST_NEW_GAP     = 15'sd400;

   // Result action codes.
   typedef enum logic [ACTION_W-1:0] {
      ACT_REJECT = 3'd0,
      ACT_NEW    = 3'd1,
      ACT_UPDATE = 3'd2,
      ACT_FRAME  = 3'd3,
      ACT_FULL   = 3'd4
   } cta_action_type;

   // One wheel of the track table.
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] r;
   } cta_entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic           capture;
      logic           clr_marks;
      logic           append;
      logic           rd_last;
      logic           scan_init;
      logic           scan_run;
      logic           update;
      logic           result;
      cta_action_type action;
   } cta_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_frame;
      logic qualified;
      logic count_zero;
      logic full;
      logic gap_ok;
      logic hit;
      logic scan_end;
      logic out_free;
   } cta_sts_type;

endpackage
`default_nettype wire

[hdl/circle_track_associator_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// circle_track_associator_top: wheel track table with candidate association
// Top level joining the sequencing controller to the table datapath.
// ============================================================================
// The block takes one request transaction at a time. A frame start or a
// candidate that fails the vote, radius or margin checks goes from the check
// state straight to the done state, as does a candidate appended to an empty
// table. Any other candidate reads the last wheel and, if it is not far
// enough left to be appended, scans the table one entry per cycle through the
// single registered read port of the track memory. The result sits in an
// output register, and the next request is accepted while it waits there.
// The track memory needs no clearing pass after reset.
module circle_track_associator_top #(
   parameter int MAX_TRACKS  = 16,
   parameter int EDGE_MARGIN = 40
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_type,
   input  wire logic [cta_pkg::COORD_W-1:0]   req_cand_x,
   input  wire logic [cta_pkg::COORD_W-1:0]   req_cand_y,
   input  wire logic [cta_pkg::COORD_W-1:0]   req_cand_r,
   input  wire logic [cta_pkg::VOTES_W-1:0]   req_votes,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [cta_pkg::ACTION_W-1:0]       rsp_action,
   output logic [cta_pkg::SLOT_W-1:0]         rsp_wheel_slot,
   output logic [cta_pkg::COORD_W-1:0]        rsp_x_position,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [cta_pkg::CFG_IDX_W-1:0] csr_index,
   input  wire logic [cta_pkg::CFG_DAT_W-1:0] csr_data
);

   cta_pkg::cta_cmd_type cmd;
   cta_pkg::cta_sts_type sts;

   // Sequencing of each transaction.
   cta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Table, gates, configuration and result register.
   cta_datapath #(
      .MAX_TRACKS  (MAX_TRACKS),
      .EDGE_MARGIN (EDGE_MARGIN)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_type       (req_type),
      .req_cand_x     (req_cand_x),
      .req_cand_y     (req_cand_y),
      .req_cand_r     (req_cand_r),
      .req_votes      (req_votes),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_action     (rsp_action),
      .rsp_wheel_slot (rsp_wheel_slot),
      .rsp_x_position (rsp_x_position),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

endmodule
`default_nettype wire

[hdl/cta_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cta_ctrl: sequencing controller of the circle track associator
// Accepts one request transaction at a time, steps the datapath through the
// qualification, gap check and table scan, and hands the result over.
// ============================================================================
module cta_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire cta_pkg::cta_sts_type sts,
   output cta_pkg::cta_cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_LAST,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type               state_ff;
   state_type               state_in;
   cta_pkg::cta_action_type act_ff;
   cta_pkg::cta_action_type act_in;

   // A new transaction is taken only while the controller is idle.
   assign req_stall = (state_ff != ST_IDLE);

   // Next state, pending action and datapath commands.
   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      cmd.capture   = 1'b0;
      cmd.clr_marks = 1'b0;
      cmd.append    = 1'b0;
      cmd.rd_last   = 1'b0;
      cmd.scan_init = 1'b0;
      cmd.scan_run  = 1'b0;
      cmd.update    = 1'b0;
      cmd.result    = 1'b0;
      cmd.action    = act_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.is_frame) begin
               cmd.clr_marks = 1'b1;
               act_in        = cta_pkg::ACT_FRAME;
               state_in      = ST_DONE;
            end else if (!sts.qualified) begin
               act_in   = cta_pkg::ACT_REJECT;
               state_in = ST_DONE;
            end else if (sts.count_zero) begin
               cmd.append = 1'b1;
               act_in     = cta_pkg::ACT_NEW;
               state_in   = ST_DONE;
            end else begin
               cmd.rd_last = 1'b1;
               state_in    = ST_LAST;
            end
         end
         ST_LAST: begin
            // The last wheel is now in the read register.
            if (sts.gap_ok) begin
               if (sts.full) begin
                  act_in = cta_pkg::ACT_FULL;
               end else begin
                  cmd.append = 1'b1;
                  act_in     = cta_pkg::ACT_NEW;
               end
               state_in = ST_DONE;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.hit) begin
               cmd.update = 1'b1;
               act_in     = cta_pkg::ACT_UPDATE;
               state_in   = ST_DONE;
            end else if (sts.scan_end) begin
               act_in   = cta_pkg::ACT_REJECT;
               state_in = ST_DONE;
            end else begin
               cmd.scan_run = 1'b1;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.result = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and pending action registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         act_ff   <= cta_pkg::ACT_REJECT;
      end else begin
         state_ff <= state_in;
         act_ff   <= act_in;
      end
   end

`ifndef NO_ASSERTIONS
   // An accepted transaction holds off the next one in the cycle after acceptance.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted twice in a row");

   // A result is only handed over when the output register can take it.
   a_result_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.result |-> sts.out_free)
      else $error("result loaded into a busy output register");
`endif

endmodule
`default_nettype wire

[hdl/cta_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cta_datapath: track table, gates and result register
// Holds the configuration registers, the captured request, the track memory
// with its single registered read port, the tracked marks, the table fill
// count and the output register of the result channel.
// ============================================================================
module cta_datapath #(
   parameter int MAX_TRACKS  = 16,
   parameter int EDGE_MARGIN = 40
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire cta_pkg::cta_cmd_type                  cmd,
   output cta_pkg::cta_sts_type                       sts,
   input  wire logic                                  req_type,
   input  wire logic [cta_pkg::COORD_W-1:0]           req_cand_x,
   input  wire logic [cta_pkg::COORD_W-1:0]           req_cand_y,
   input  wire logic [cta_pkg::COORD_W-1:0]           req_cand_r,
   input  wire logic [cta_pkg::VOTES_W-1:0]           req_votes,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [cta_pkg::ACTION_W-1:0]               rsp_action,
   output logic [cta_pkg::SLOT_W-1:0]                 rsp_wheel_slot,
   output logic [cta_pkg::COORD_W-1:0]                rsp_x_position,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [cta_pkg::CFG_IDX_W-1:0]         csr_index,
   input  wire logic [cta_pkg::CFG_DAT_W-1:0]         csr_data
);

   localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   localparam int CNT_W = $clog2(MAX_TRACKS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TRACKS);
   localparam logic [cta_pkg::STEP_W-1:0] EDGE_W = cta_pkg::STEP_W'(EDGE_MARGIN);

   // Configuration registers.
   logic [cta_pkg::COORD_W-1:0]       frame_width_ff;
   logic [cta_pkg::COORD_W-1:0]       min_radius_ff;
   logic [cta_pkg::COORD_W-1:0]       max_radius_ff;
   logic signed [cta_pkg::STEP_W-1:0] min_x_step_ff;
   logic signed [cta_pkg::STEP_W-1:0] max_x_step_ff;
   logic [cta_pkg::COORD_W-1:0]       max_y_diff_ff;
   logic [cta_pkg::COORD_W-1:0]       max_r_diff_ff;
   logic signed [cta_pkg::STEP_W-1:0] new_gap_ff;

   // Captured request.
   logic                        type_ff;
   logic [cta_pkg::COORD_W-1:0] x_ff;
   logic [cta_pkg::COORD_W-1:0] y_ff;
   logic [cta_pkg::COORD_W-1:0] r_ff;
   logic [cta_pkg::VOTES_W-1:0] votes_ff;

   // Track table and scan state.
   cta_pkg::cta_entry_type mem [MAX_TRACKS];
   cta_pkg::cta_entry_type rd_data_ff;
   cta_pkg::cta_entry_type wr_data;
   logic [IDX_W-1:0]       rd_idx_ff;
   logic                   rd_vld_ff;
   logic [MAX_TRACKS-1:0]  mark_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_m1;
   logic [CNT_W-1:0]       scan_ff;
   logic [IDX_W-1:0]       count_idx;
   logic [IDX_W-1:0]       rd_addr;
   logic [IDX_W-1:0]       wr_addr;
   logic                   rd_en;
   logic                   wr_en;
   logic                   scan_more;
   logic [IDX_W-1:0]       slot_ff;
   logic [IDX_W+cta_pkg::SLOT_W-1:0] slot_wide;

   // Gate arithmetic.
   logic signed [cta_pkg::STEP_W-1:0] gap_diff;
   logic signed [cta_pkg::STEP_W-1:0] x_off;
   logic [cta_pkg::COORD_W-1:0]       y_abs;
   logic [cta_pkg::COORD_W-1:0]       r_abs;
   logic                              qualified;

   // Output register.
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [cta_pkg::ACTION_W-1:0] rsp_action_ff;
   logic [cta_pkg::SLOT_W-1:0]  rsp_slot_ff;
   logic [cta_pkg::COORD_W-1:0] rsp_x_ff;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff <= cta_pkg::RST_FRAME_WIDTH;
         min_radius_ff  <= cta_pkg::RST_MIN_RADIUS;
         max_radius_ff  <= cta_pkg::RST_MAX_RADIUS;
         min_x_step_ff  <= cta_pkg::RST_MIN_X_STEP;
         max_x_step_ff  <= cta_pkg::RST_MAX_X_STEP;
         max_y_diff_ff  <= cta_pkg::RST_MAX_Y_DIFF;
         max_r_diff_ff  <= cta_pkg::RST_MAX_R_DIFF;
         new_gap_ff     <= cta_pkg::RST_NEW_GAP;
      end else if (csr_valid) begin
         unique case (csr_index)
            cta_pkg::CFG_FRAME_WIDTH: frame_width_ff <= csr_data[cta_pkg::COORD_W-1:0];
            cta_pkg::CFG_MIN_RADIUS:  min_radius_ff  <= csr_data[cta_pkg::COORD_W-1:0];
            cta_pkg::CFG_MAX_RADIUS:  max_radius_ff  <= csr_data[cta_pkg::COORD_W-1:0];
            cta_pkg::CFG_MIN_X_STEP:  min_x_step_ff  <= $signed(csr_data);
            cta_pkg::CFG_MAX_X_STEP:  max_x_step_ff  <= $signed(csr_data);
            cta_pkg::CFG_MAX_Y_DIFF:  max_y_diff_ff  <= csr_data[cta_pkg::COORD_W-1:0];
            cta_pkg::CFG_MAX_R_DIFF:  max_r_diff_ff  <= csr_data[cta_pkg::COORD_W-1:0];
            cta_pkg::CFG_NEW_GAP:     new_gap_ff     <= $signed(csr_data);
            default: begin
            end
         endcase
      end
   end

   // Capture the request transaction.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff  <= req_type;
         x_ff     <= req_cand_x;
         y_ff     <= req_cand_y;
         r_ff     <= req_cand_r;
         votes_ff <= req_votes;
      end
   end

   // Candidate qualification: votes, radius window and frame margins.
   assign qualified = (votes_ff > cta_pkg::VOTE_LIMIT) &&
                      (r_ff > min_radius_ff) && (r_ff < max_radius_ff) &&
                      ({1'b0, x_ff} > EDGE_W) &&
                      (({1'b0, x_ff} + EDGE_W) < {1'b0, frame_width_ff});

   // Index helpers for the table.
   assign count_m1  = count_ff - 1'b1;
   assign count_idx = count_ff[IDX_W-1:0];
   assign scan_more = (scan_ff < count_ff);

   // Read port: the last wheel for the gap check, or the next scan entry.
   assign rd_en   = cmd.rd_last || (cmd.scan_run && scan_more);
   assign rd_addr = cmd.rd_last ? count_m1[IDX_W-1:0] : scan_ff[IDX_W-1:0];

   // Write port: an appended wheel or an updated one.
   assign wr_en        = cmd.append || cmd.update;
   assign wr_addr      = cmd.append ? count_idx : rd_idx_ff;
   assign wr_data.x    = x_ff;
   assign wr_data.y    = y_ff;
   assign wr_data.r    = r_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_idx_ff  <= rd_addr;
      end
   end

   // Scan pointer and valid flag of the read register.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff   <= '0;
         rd_vld_ff <= 1'b0;
      end else if (cmd.scan_init) begin
         scan_ff   <= '0;
         rd_vld_ff <= 1'b0;
      end else if (cmd.scan_run) begin
         rd_vld_ff <= scan_more;
         if (scan_more) begin
            scan_ff <= scan_ff + 1'b1;
         end
      end else if (cmd.rd_last) begin
         rd_vld_ff <= 1'b0;
      end
   end

   // Table fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.append) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   // Tracked marks: cleared by a frame start or, for its slot, by an append, set by an update.
   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff <= '0;
      end else if (cmd.clr_marks) begin
         mark_ff <= '0;
      end else if (cmd.append) begin
         mark_ff[count_idx] <= 1'b0;
      end else if (cmd.update) begin
         mark_ff[rd_idx_ff] <= 1'b1;
      end
   end

   // Slot of the wheel that was appended or updated.
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         slot_ff <= count_idx;
      end else if (cmd.update) begin
         slot_ff <= rd_idx_ff;
      end
   end

   // Gap from the last wheel and the tracking gates.
   assign gap_diff = $signed({1'b0, rd_data_ff.x}) - $signed({1'b0, x_ff});
   assign x_off    = $signed({1'b0, x_ff}) - $signed({1'b0, rd_data_ff.x});
   assign y_abs    = (y_ff > rd_data_ff.y) ? (y_ff - rd_data_ff.y) : (rd_data_ff.y - y_ff);
   assign r_abs    = (r_ff > rd_data_ff.r) ? (r_ff - rd_data_ff.r) : (rd_data_ff.r - r_ff);

   // Status toward the controller.
   assign sts.is_frame   = (type_ff == cta_pkg::REQ_FRAME);
   assign sts.qualified  = qualified;
   assign sts.count_zero = (count_ff == '0);
   assign sts.full       = (count_ff >= CNT_MAX);
   assign sts.gap_ok     = (gap_diff > new_gap_ff);
   assign sts.hit        = rd_vld_ff && !mark_ff[rd_idx_ff] &&
                           (x_off > min_x_step_ff) && (x_off < max_x_step_ff) &&
                           (y_abs < max_y_diff_ff) && (r_abs < max_r_diff_ff);
   assign sts.scan_end   = !rd_vld_ff && (scan_ff == count_ff);
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   // Result output register.
   assign slot_wide = {{cta_pkg::SLOT_W{1'b0}}, slot_ff};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.result) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result) begin
         rsp_action_ff <= cmd.action;
         if (cmd.action == cta_pkg::ACT_NEW || cmd.action == cta_pkg::ACT_UPDATE) begin
            rsp_slot_ff <= slot_wide[cta_pkg::SLOT_W-1:0];
            rsp_x_ff    <= x_ff;
         end else begin
            rsp_slot_ff <= '0;
            rsp_x_ff    <= '0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_action     = rsp_action_ff;
   assign rsp_wheel_slot = rsp_slot_ff;
   assign rsp_x_position = rsp_x_ff;

`ifndef NO_ASSERTIONS
   // The fill count never passes the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("track count beyond table depth");

   // A wheel is appended only while the table has room.
   a_append_room: assert property (@(posedge clock) disable iff (reset)
      cmd.append |-> (count_ff < CNT_MAX))
      else $error("append into a full table");

   // An update targets a valid scanned entry inside the filled table.
   a_update_idx: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> (rd_vld_ff && (CNT_W'(rd_idx_ff) < count_ff)))
      else $error("update of an entry outside the table");

   // A frame start leaves every wheel untracked.
   a_marks_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_marks |=> (mark_ff == '0))
      else $error("tracked marks not cleared by frame start");
`endif

endmodule
`default_nettype wire

[tb/tb_circle_track_associator_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_circle_track_associator_top: self-checking bench for the wheel tracker
// Drives frame starts and candidate circles through the request channel and
// compares every result with a wheel table kept in the bench. A directed
// opening covers the gate edges. Random phases then follow real wheels
// across several register settings, fill the table, and keep working on a
// full table.
// ============================================================================
module tb_circle_track_associator_top;
   import cta_pkg::*;

   localparam int CLK_HALF      = 4;
   localparam int RESET_CYCLES  = 10;
   localparam int TRACK_SLOTS   = 16;
   localparam int EDGE_GUARD    = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 40;
   localparam int TIMEOUT_NS    = 4_000_000;
   localparam int COORD_TOP     = (1 << COORD_W) - 1;
   localparam int VOTES_TOP     = (1 << VOTES_W) - 1;

   // One request transaction as the bench sees it.
   typedef struct packed {
      logic               kind;
      logic [COORD_W-1:0] cand_x;
      logic [COORD_W-1:0] cand_y;
      logic [COORD_W-1:0] cand_r;
      logic [VOTES_W-1:0] votes;
   } cand_req_type;

   // One result transaction awaited from the block.
   typedef struct {
      cta_action_type     action;
      logic [SLOT_W-1:0]  slot;
      logic [COORD_W-1:0] xpos;
   } wheel_outcome_type;

   // Receiver stall patterns.
   typedef enum int {PACE_FREE, PACE_SPARSE, PACE_PERIODIC, PACE_HEAVY} pace_mode_type;

   // Wheel table kept by the bench, plus the queue of results still owed.
   class wheel_track_scoreboard #(parameter int SLOTS = 16, parameter int MARGIN = 40);
      int frame_width, min_radius, max_radius, max_y_diff, max_r_diff;
      int min_x_step, max_x_step, new_gap;
      logic [COORD_W-1:0] track_x [SLOTS];
      logic [COORD_W-1:0] track_y [SLOTS];
      logic [COORD_W-1:0] track_r [SLOTS];
      bit tracked [SLOTS];
      int track_count;
      int fault_count;
      wheel_outcome_type owed_q[$];

      function new();
         frame_width = int'(RST_FRAME_WIDTH);
         min_radius  = int'(RST_MIN_RADIUS);
         max_radius  = int'(RST_MAX_RADIUS);
         min_x_step  = int'(RST_MIN_X_STEP);
         max_x_step  = int'(RST_MAX_X_STEP);
         max_y_diff  = int'(RST_MAX_Y_DIFF);
         max_r_diff  = int'(RST_MAX_R_DIFF);
         new_gap     = int'(RST_NEW_GAP);
         foreach (tracked[i]) tracked[i] = 1'b0;
         track_count = 0;
         fault_count = 0;
      endfunction

      // Unsigned registers keep the low 14 bits; step and gap registers are signed.
      function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
         case (idx)
            CFG_FRAME_WIDTH: frame_width = int'(data[COORD_W-1:0]);
            CFG_MIN_RADIUS:  min_radius  = int'(data[COORD_W-1:0]);
            CFG_MAX_RADIUS:  max_radius  = int'(data[COORD_W-1:0]);
            CFG_MIN_X_STEP:  min_x_step  = int'(signed'(data));
            CFG_MAX_X_STEP:  max_x_step  = int'(signed'(data));
            CFG_MAX_Y_DIFF:  max_y_diff  = int'(data[COORD_W-1:0]);
            CFG_MAX_R_DIFF:  max_r_diff  = int'(data[COORD_W-1:0]);
            CFG_NEW_GAP:     new_gap     = int'(signed'(data));
            default: ;
         endcase
      endfunction

      // Works out the result of one request and updates the table.
      function wheel_outcome_type associate(cand_req_type rq);
         wheel_outcome_type res;
         int x, y, r, off, dy, dr;
         res.action = ACT_REJECT;
         res.slot   = '0;
         res.xpos   = '0;
         if (rq.kind == REQ_FRAME) begin
            foreach (tracked[i]) tracked[i] = 1'b0;
            res.action = ACT_FRAME;
            return res;
         end
         x = int'(rq.cand_x);
         y = int'(rq.cand_y);
         r = int'(rq.cand_r);
         if (rq.votes <= VOTE_LIMIT) return res;
         if (r <= min_radius || r >= max_radius) return res;
         if (x <= MARGIN || x >= frame_width - MARGIN) return res;
         // Far enough left of the last wheel, or nothing yet: append.
         if (track_count == 0 || int'(track_x[track_count-1]) - x > new_gap) begin
            if (track_count >= SLOTS) begin
               res.action = ACT_FULL;
               return res;
            end
            track_x[track_count] = rq.cand_x;
            track_y[track_count] = rq.cand_y;
            track_r[track_count] = rq.cand_r;
            tracked[track_count] = 1'b0;
            res.action = ACT_NEW;
            res.slot   = track_count[SLOT_W-1:0];
            res.xpos   = rq.cand_x;
            track_count++;
            return res;
         end
         // Otherwise the first untracked wheel inside every gate takes it.
         for (int i = 0; i < track_count; i++) begin
            if (tracked[i]) continue;
            off = x - int'(track_x[i]);
            dy  = y > int'(track_y[i]) ? y - int'(track_y[i]) : int'(track_y[i]) - y;
            dr  = r > int'(track_r[i]) ? r - int'(track_r[i]) : int'(track_r[i]) - r;
            if (off > min_x_step && off < max_x_step && dy < max_y_diff &&
                dr < max_r_diff) begin
               track_x[i] = rq.cand_x;
               track_y[i] = rq.cand_y;
               track_r[i] = rq.cand_r;
               tracked[i] = 1'b1;
               res.action = ACT_UPDATE;
               res.slot   = i[SLOT_W-1:0];
               res.xpos   = rq.cand_x;
               return res;
            end
         end
         return res;
      endfunction

      function void note_request(cand_req_type rq);
         owed_q.insert(owed_q.size(), associate(rq));
      endfunction

      function int outstanding();
         return owed_q.size();
      endfunction

      function void check_result(logic [ACTION_W-1:0] act, logic [SLOT_W-1:0] slot,
                                 logic [COORD_W-1:0] xpos);
         wheel_outcome_type want;
         if (owed_q.size() == 0) begin
            $error("result with no request outstanding: action %0d slot %0d x %0d",
                   act, slot, xpos);
            fault_count++;
            return;
         end
         want = owed_q.pop_front();
         if (act !== want.action) begin
            $error("rsp_action mismatch: expected %0d, actual %0d", want.action, act);
            fault_count++;
         end
         if (slot !== want.slot) begin
            $error("rsp_wheel_slot mismatch: expected %0d, actual %0d", want.slot, slot);
            fault_count++;
         end
         if (xpos !== want.xpos) begin
            $error("rsp_x_position mismatch: expected %0d, actual %0d", want.xpos, xpos);
            fault_count++;
         end
      endfunction
   endclass

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_type       = REQ_FRAME;
   logic [COORD_W-1:0]   req_cand_x     = '0;
   logic [COORD_W-1:0]   req_cand_y     = '0;
   logic [COORD_W-1:0]   req_cand_r     = '0;
   logic [VOTES_W-1:0]   req_votes      = '0;
   logic                 rsp_stall      = 1'b0;
   logic                 csr_valid      = 1'b0;
   logic [CFG_IDX_W-1:0] csr_index      = '0;
   logic [CFG_DAT_W-1:0] csr_data       = '0;
   logic                 req_stall;
   logic                 rsp_valid;
   logic [ACTION_W-1:0]  rsp_action;
   logic [SLOT_W-1:0]    rsp_wheel_slot;
   logic [COORD_W-1:0]   rsp_x_position;
   logic                 csr_ready;

   wheel_track_scoreboard #(.SLOTS(TRACK_SLOTS), .MARGIN(EDGE_GUARD)) sb;
   bit hold_request = 1'b0;
   int burst_left   = 0;

   circle_track_associator_top #(
      .MAX_TRACKS  (TRACK_SLOTS),
      .EDGE_MARGIN (EDGE_GUARD)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_cand_x     (req_cand_x),
      .req_cand_y     (req_cand_y),
      .req_cand_r     (req_cand_r),
      .req_votes      (req_votes),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_action     (rsp_action),
      .rsp_wheel_slot (rsp_wheel_slot),
      .rsp_x_position (rsp_x_position),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // Free-running clock.
   always #CLK_HALF clock = ~clock;

   // Every result transaction is checked against the oldest one owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_action, rsp_wheel_slot, rsp_x_position);
      end
   end

   // Receiver: changing stall patterns, plus one long hold when asked.
   initial begin : rsp_pacer
      pace_mode_type mode;
      int seg;
      forever begin
         if (hold_request) begin
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
            hold_request = 1'b0;
         end else begin
            mode = pace_mode_type'($urandom_range(PACE_FREE, PACE_HEAVY));
            seg  = $urandom_range(10, 60);
            for (int c = 0; c < seg; c++) begin
               @(negedge clock);
               case (mode)
                  PACE_FREE:     rsp_stall <= 1'b0;
                  PACE_SPARSE:   rsp_stall <= ($urandom_range(0, 3) == 0);
                  PACE_PERIODIC: rsp_stall <= (c % 3 == 2);
                  default:       rsp_stall <= ($urandom_range(0, 1) == 1);
               endcase
            end
         end
      end
   end

   // Run limit in case the block hangs.
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("*** FAILED ***");
      $finish;
   end

   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // Offers one request transaction and holds it until it is taken.
   task automatic drive_item(input cand_req_type rq);
      @(negedge clock);
      req_valid  <= 1'b1;
      req_type   <= rq.kind;
      req_cand_x <= rq.cand_x;
      req_cand_y <= rq.cand_y;
      req_cand_r <= rq.cand_r;
      req_votes  <= rq.votes;
      do begin
         @(posedge clock);
      end while (req_stall);
      sb.note_request(rq);
   endtask

   // Bursts of back-to-back requests separated by random gaps.
   task automatic offer(input cand_req_type rq);
      drive_item(rq);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         idle_cycles($urandom_range(0, 6));
         burst_left = $urandom_range(1, 16);
      end
   endtask

   task automatic send_cand(input int x, input int y, input int r, input int v);
      cand_req_type rq;
      rq.kind   = REQ_CAND;
      rq.cand_x = x[COORD_W-1:0];
      rq.cand_y = y[COORD_W-1:0];
      rq.cand_r = r[COORD_W-1:0];
      rq.votes  = v[VOTES_W-1:0];
      offer(rq);
   endtask

   task automatic send_frame();
      cand_req_type rq;
      rq.kind   = REQ_FRAME;
      rq.cand_x = COORD_W'(COORD_TOP);
      rq.cand_y = COORD_W'(COORD_TOP);
      rq.cand_r = COORD_W'(COORD_TOP);
      rq.votes  = VOTES_W'(VOTES_TOP);
      offer(rq);
   endtask

   // Stops offering and waits for every owed result.
   task automatic drain_results();
      idle_cycles(1);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DAT_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      sb.set_reg(idx, data);
   endtask

   // Writes all eight registers; the unused top bit of unsigned ones is random.
   task automatic apply_config(input int fw, input int minr, input int maxr,
                               input int minx, input int maxx, input int ydiff,
                               input int rdiff, input int gap);
      csr_write(CFG_FRAME_WIDTH, {1'($urandom_range(0, 1)), fw[COORD_W-1:0]});
      csr_write(CFG_MIN_RADIUS,  {1'($urandom_range(0, 1)), minr[COORD_W-1:0]});
      csr_write(CFG_MAX_RADIUS,  {1'($urandom_range(0, 1)), maxr[COORD_W-1:0]});
      csr_write(CFG_MIN_X_STEP,  minx[STEP_W-1:0]);
      csr_write(CFG_MAX_X_STEP,  maxx[STEP_W-1:0]);
      csr_write(CFG_MAX_Y_DIFF,  {1'($urandom_range(0, 1)), ydiff[COORD_W-1:0]});
      csr_write(CFG_MAX_R_DIFF,  {1'($urandom_range(0, 1)), rdiff[COORD_W-1:0]});
      csr_write(CFG_NEW_GAP,     gap[STEP_W-1:0]);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly candidates that follow a known wheel near its gates, with frame
   // starts, appends left of the last wheel, and fully random noise mixed in.
   function automatic cand_req_type make_request();
      cand_req_type rq;
      int pick, s, span, x, y, r, w;
      pick      = $urandom_range(0, 99);
      rq.kind   = REQ_CAND;
      rq.cand_x = COORD_W'($urandom_range(0, COORD_TOP));
      rq.cand_y = COORD_W'($urandom_range(0, COORD_TOP));
      rq.cand_r = COORD_W'($urandom_range(0, COORD_TOP));
      rq.votes  = VOTES_W'($urandom_range(0, VOTES_TOP));
      if (pick < 8) begin
         rq.kind = REQ_FRAME;
      end else if (pick < 22) begin
         // Noise: keep every field random.
      end else if (pick < 34 || sb.track_count == 0) begin
         if (sb.track_count == 0) begin
            x = $urandom_range(0, 2600);
         end else begin
            x = int'(sb.track_x[sb.track_count-1]) - sb.new_gap
                - int'($urandom_range(0, 300)) + 1;
         end
         r = sb.min_radius + int'($urandom_range(0, 320)) - 1;
         rq.cand_x = x[COORD_W-1:0];
         rq.cand_y = COORD_W'($urandom_range(0, 2000));
         rq.cand_r = r[COORD_W-1:0];
         rq.votes  = VOTES_W'($urandom_range(12, VOTES_TOP));
      end else begin
         s    = $urandom_range(0, sb.track_count - 1);
         span = sb.max_x_step - sb.min_x_step + 2;
         if (span < 2) span = 2;
         if (span > 800) span = 800;
         x = int'(sb.track_x[s]) + sb.min_x_step - 1 + int'($urandom_range(0, span));
         w = sb.max_y_diff > 300 ? 300 : sb.max_y_diff;
         y = int'(sb.track_y[s]) - w - 1 + int'($urandom_range(0, 2 * w + 2));
         w = sb.max_r_diff > 300 ? 300 : sb.max_r_diff;
         r = int'(sb.track_r[s]) - w - 1 + int'($urandom_range(0, 2 * w + 2));
         rq.cand_x = x[COORD_W-1:0];
         rq.cand_y = y[COORD_W-1:0];
         rq.cand_r = r[COORD_W-1:0];
         rq.votes  = VOTES_W'($urandom_range(12, VOTES_TOP));
      end
      return rq;
   endfunction

   task automatic run_random(input int n);
      repeat (n) offer(make_request());
   endtask

   // Main sequence.
   initial begin : stimulus
      int fill;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Opening with reset settings: vote, radius and margin edges, then
      // append, update, tracked skip, frame clear and the gate edges.
      apply_config(2560, 80, 400, 0, 400, 40, 40, 400);
      send_frame();
      send_cand(1000, 500, 200, 15);
      send_cand(0, 0, 0, 0);
      send_cand(1000, 500, 80, 200);
      send_cand(1000, 500, 400, 200);
      send_cand(40, 500, 200, 200);
      send_cand(2520, 500, 200, 200);
      send_cand(COORD_TOP, COORD_TOP, COORD_TOP, VOTES_TOP);
      send_cand(2000, 500, 200, 16);
      send_cand(2000, 500, 200, 100);
      send_cand(2100, 510, 210, VOTES_TOP);
      send_cand(2150, 510, 210, 200);
      send_frame();
      send_cand(1500, 300, 150, 50);
      send_cand(1600, 300, 150, 50);
      send_cand(2500, 510, 210, 50);
      send_cand(2499, 510, 210, 50);
      send_frame();
      send_cand(1200, 800, 300, 50);
      send_cand(1199, 1000, 300, 50);
      send_cand(1250, 1040, 300, 50);
      send_cand(1250, 1000, 340, 50);
      send_cand(1250, 1039, 339, 50);

      // Random traffic; the receiver holds off for a long stretch meanwhile.
      hold_request = 1'b1;
      run_random(130);
      drain_results();

      // Wheels moving left with wide windows.
      apply_config(COORD_TOP, 0, COORD_TOP, -400, 0, 200, 200, 1000);
      run_random(120);
      drain_results();

      // Empty and inverted windows: every candidate is rejected.
      apply_config(0, COORD_TOP, 0, 16383, -16383, 0, 0, -16383);
      run_random(20);
      drain_results();

      // Every qualified candidate appends until the table is full.
      apply_config(2560, 80, 400, -16383, 16383, COORD_TOP, COORD_TOP, -16383);
      fill = TRACK_SLOTS - sb.track_count + 4;
      repeat (fill) begin
         send_cand($urandom_range(41, 2519), $urandom_range(0, COORD_TOP),
                   $urandom_range(81, 399), $urandom_range(16, VOTES_TOP));
      end
      run_random(10);
      drain_results();

      // Full table: updates continue, appends are dropped.
      apply_config(4000, 20, 1000, -50, 300, 100, 60, 200);
      run_random(80);
      drain_results();
      run_random(80);

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.outstanding() != 0) begin
         $error("%0d results never arrived", sb.outstanding());
         sb.fault_count++;
      end
      if (sb.fault_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/cta_pkg.sv
hdl/cta_ctrl.sv
hdl/cta_datapath.sv
hdl/circle_track_associator_top.sv
tb/tb_circle_track_associator_top.sv
